/* src/sphere_pair_contact_test_core_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the sphere pair contact test core
// Each macro expects clk and rst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef SPHERE_PAIR_CONTACT_TEST_CORE_DEFINES_SVH
`define SPHERE_PAIR_CONTACT_TEST_CORE_DEFINES_SVH

// Same-cycle implication
`define SPCT_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication
`define SPCT_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* src/spct_pkg.sv */
// ---------------------------------------------------------------------------
// spct_pkg
// Fixed field widths shared by the contact test pipeline.
// ---------------------------------------------------------------------------
package spct_pkg;

  // radius input, radius sum, depth and scale factor widths
  localparam int RADIUS_W = 30;
  localparam int RSUM_W   = 31;
  localparam int DEPTH_W  = 31;
  localparam int SCALE_W  = 31;

endpackage

/* src/spct_sqsum.sv */
// ---------------------------------------------------------------------------
// spct_sqsum
// Centre difference, magnitudes and squared length over four stages.
// ---------------------------------------------------------------------------
module spct_sqsum #(
  parameter int CW = 32,
  parameter int MW = 33,
  parameter int SW = 66
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic [2:0][CW-1:0]              a,
  input  logic [2:0][CW-1:0]              b,
  input  logic [spct_pkg::RADIUS_W-1:0]   ra,
  input  logic [spct_pkg::RADIUS_W-1:0]   rb,
  output logic                            out_vld,
  output logic [SW-1:0]                   sq,
  output logic [2:0][CW-1:0]              a_o,
  output logic [2:0]                      dn_o,
  output logic [2:0][MW-1:0]              dm_o,
  output logic [spct_pkg::RADIUS_W-1:0]   ra_o,
  output logic [spct_pkg::RSUM_W-1:0]     rsum_o
);
  import spct_pkg::*;

  localparam int K  = (MW + 1) / 2;
  localparam int HW = MW - K;

  logic [3:0]              vld_r;
  logic [2:0][CW-1:0]      a_r    [4];
  logic [2:0]              dn_r   [4];
  logic [2:0][MW-1:0]      dm_r   [4];
  logic [RADIUS_W-1:0]     ra_r   [4];
  logic [RSUM_W-1:0]       rsum_r [4];
  logic [2:0][2*HW-1:0]    hh_r;
  logic [2:0][MW-1:0]      hl_r;
  logic [2:0][2*K-1:0]     ll_r;
  logic [2:0][SW-1:0]      ax_r;
  logic [SW-1:0]           sq_r;

  logic [2:0][CW:0]        d_c;
  logic [2:0]              dn_c;
  logic [2:0][MW-1:0]      dm_c;

  // form B - A and its magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_c[i]  = {b[i][CW-1], b[i]} - {a[i][CW-1], a[i]};
      dn_c[i] = d_c[i][CW];
      dm_c[i] = dn_c[i] ? MW'(~d_c[i] + 1'b1) : MW'(d_c[i]);
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0]    <= a;
      dn_r[0]   <= dn_c;
      dm_r[0]   <= dm_c;
      ra_r[0]   <= ra;
      rsum_r[0] <= RSUM_W'(ra) + RSUM_W'(rb);
      for (int k = 1; k < 4; k++) begin
        a_r[k]    <= a_r[k-1];
        dn_r[k]   <= dn_r[k-1];
        dm_r[k]   <= dm_r[k-1];
        ra_r[k]   <= ra_r[k-1];
        rsum_r[k] <= rsum_r[k-1];
      end
      // split squares into half-width partial products
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= dm_r[0][i][MW-1:K] * dm_r[0][i][MW-1:K];
        hl_r[i] <= dm_r[0][i][MW-1:K] * dm_r[0][i][K-1:0];
        ll_r[i] <= dm_r[0][i][K-1:0] * dm_r[0][i][K-1:0];
      end
      // recombine each axis
      for (int i = 0; i < 3; i++) begin
        ax_r[i] <= (SW'(hh_r[i]) << (2 * K)) + (SW'(hl_r[i]) << (K + 1)) + SW'(ll_r[i]);
      end
      sq_r <= ax_r[0] + ax_r[1] + ax_r[2];
    end
  end

  assign out_vld = vld_r[3];
  assign sq      = sq_r;
  assign a_o     = a_r[3];
  assign dn_o    = dn_r[3];
  assign dm_o    = dm_r[3];
  assign ra_o    = ra_r[3];
  assign rsum_o  = rsum_r[3];

endmodule

/* src/spct_sqrt.sv */
// ---------------------------------------------------------------------------
// spct_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ---------------------------------------------------------------------------
module spct_sqrt #(
  parameter int RB     = 33,
  parameter int SW     = 66,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [SW-1:0]     rad,
  input  logic [SIDE_W-1:0] side,
  output logic              out_vld,
  output logic [RB-1:0]     root,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_r  [RB];
  logic [RB:0]       rem_r  [RB];
  logic [RB-1:0]     root_r [RB];
  logic [SW-1:0]     rad_r  [RB];
  logic [SIDE_W-1:0] side_r [RB];

  for (genvar i = 0; i < RB; i++) begin : g_stage
    logic              vld_p;
    logic [RB:0]       rem_p;
    logic [RB-1:0]     root_p;
    logic [SW-1:0]     rad_p;
    logic [SIDE_W-1:0] side_p;
    logic [RB+2:0]     remx;
    logic [RB+2:0]     trial;
    logic [RB+2:0]     diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign vld_p  = in_vld;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad;
      assign side_p = side;
    end else begin : g_next
      assign vld_p  = vld_r[i-1];
      assign rem_p  = rem_r[i-1];
      assign root_p = root_r[i-1];
      assign rad_p  = rad_r[i-1];
      assign side_p = side_r[i-1];
    end

    // bring down two radicand bits and try the next root bit
    always_comb begin
      remx  = {rem_p, rad_p[SW-1:SW-2]};
      trial = {1'b0, root_p, 2'b01};
      diff  = remx - trial;
      ge    = (remx >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? diff[RB:0] : remx[RB:0];
        root_r[i] <= {root_p[RB-2:0], ge};
        rad_r[i]  <= {rad_p[SW-3:0], 2'b00};
        side_r[i] <= side_p;
      end
    end
  end

  assign out_vld = vld_r[RB-1];
  assign root    = root_r[RB-1];
  assign side_o  = side_r[RB-1];

endmodule

/* src/spct_norm.sv */
// ---------------------------------------------------------------------------
// spct_norm
// Three-lane pipelined restoring divider for the rounded unit normal.
// ---------------------------------------------------------------------------
module spct_norm #(
  parameter int MW     = 33,
  parameter int F      = 15,
  parameter int SIDE_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [2:0][MW-1:0] dm,
  input  logic [MW-1:0]      dlen,
  input  logic [SIDE_W-1:0]  side,
  output logic               out_vld,
  output logic [2:0][F:0]    q,
  output logic [MW-1:0]      dist_o,
  output logic [SIDE_W-1:0]  side_o
);

  localparam int Q  = F + 1;
  localparam int NW = MW + F + 1;

  logic               vld_r  [Q];
  logic [2:0][NW-1:0] rem_r  [Q];
  logic [2:0][Q-1:0]  q_r    [Q];
  logic [MW-1:0]      dist_r [Q];
  logic [SIDE_W-1:0]  side_r [Q];

  for (genvar j = 0; j < Q; j++) begin : g_stage
    localparam int S = Q - 1 - j;
    logic               vld_p;
    logic [2:0][NW-1:0] rem_p;
    logic [2:0][NW-1:0] rem_n;
    logic [2:0][Q-1:0]  q_p;
    logic [2:0][Q-1:0]  q_n;
    logic [MW-1:0]      dist_p;
    logic [SIDE_W-1:0]  side_p;
    logic [NW-1:0]      dsh;

    if (j == 0) begin : g_first
      // dividend is |d| scaled up plus half the divisor
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          rem_p[l] = (NW'(dm[l]) << F) + NW'(dlen >> 1);
        end
      end
      assign vld_p  = in_vld;
      assign q_p    = '0;
      assign dist_p = dlen;
      assign side_p = side;
    end else begin : g_next
      assign vld_p  = vld_r[j-1];
      assign rem_p  = rem_r[j-1];
      assign q_p    = q_r[j-1];
      assign dist_p = dist_r[j-1];
      assign side_p = side_r[j-1];
    end

    // subtract the shifted divisor where it fits
    always_comb begin
      dsh = NW'(dist_p) << S;
      for (int l = 0; l < 3; l++) begin
        if (rem_p[l] >= dsh) begin
          rem_n[l] = rem_p[l] - dsh;
          q_n[l]   = q_p[l] | (Q'(1) << S);
        end else begin
          rem_n[l] = rem_p[l];
          q_n[l]   = q_p[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_n;
        q_r[j]    <= q_n;
        dist_r[j] <= dist_p;
        side_r[j] <= side_p;
      end
    end
  end

  assign out_vld = vld_r[Q-1];
  assign q       = q_r[Q-1];
  assign dist_o  = dist_r[Q-1];
  assign side_o  = side_r[Q-1];

endmodule

/* src/spct_contact.sv */
// ---------------------------------------------------------------------------
// spct_contact
// Depth, normal clamp, contact point scaling, saturation and output register.
// ---------------------------------------------------------------------------
`include "sphere_pair_contact_test_core_defines.svh"

module spct_contact #(
  parameter int CW = 32,
  parameter int MW = 33,
  parameter int F  = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [2:0][CW-1:0]            a,
  input  logic [2:0]                    dn,
  input  logic [2:0][F:0]               q,
  input  logic [MW-1:0]                 dlen,
  input  logic [spct_pkg::RADIUS_W-1:0] ra,
  input  logic [spct_pkg::RSUM_W-1:0]   rsum,
  output logic                          out_valid,
  output logic                          out_in_contact,
  output logic [2:0][F:0]               out_normal,
  output logic [spct_pkg::DEPTH_W-1:0]  out_depth,
  output logic [2:0][CW-1:0]            out_contact
);
  import spct_pkg::*;

  localparam int LW  = (MW > RSUM_W) ? MW : RSUM_W;
  localparam int PW  = SCALE_W + F + 1;
  localparam int CXW = ((CW > SCALE_W) ? CW : SCALE_W) + 2;
  localparam logic [F-1:0] NMAX = '1;
  localparam logic signed [CXW-1:0] LIM_HI = {{(CXW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [CXW-1:0] LIM_LO = {{(CXW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic [F:0] NMIN = {1'b1, {F{1'b0}}};

  // stage 1: contact test, depth, normal clamp
  logic                vld1_r, hit1_r;
  logic [DEPTH_W-1:0]  depth1_r;
  logic [2:0][F-1:0]   nm1_r;
  logic [2:0][CW-1:0]  a1_r;
  logic [2:0]          dn1_r;
  logic [RADIUS_W-1:0] ra1_r;
  logic [LW-1:0]       dep_w;
  logic [2:0][F-1:0]   nm_c;

  // stage 2: scale factor 2*ra - depth
  logic                vld2_r, hit2_r;
  logic [DEPTH_W-1:0]  depth2_r;
  logic [2:0][F-1:0]   nm2_r;
  logic [2:0][CW-1:0]  a2_r;
  logic [2:0]          dn2_r, sn2_r;
  logic [SCALE_W-1:0]  smag2_r;
  logic [SCALE_W-1:0]  two_ra;
  logic                sneg_c;

  // stage 3: scale times normal
  logic                vld3_r, hit3_r;
  logic [DEPTH_W-1:0]  depth3_r;
  logic [2:0][F-1:0]   nm3_r;
  logic [2:0][CW-1:0]  a3_r;
  logic [2:0]          dn3_r, sn3_r;
  logic [2:0][PW-1:0]  prod3_r;

  // stage 4: output register
  logic                    out_valid_r, hit4_r;
  logic [DEPTH_W-1:0]      depth4_r;
  logic [2:0][F:0]         norm4_r;
  logic [2:0][CW-1:0]      cpt4_r;
  logic [2:0][PW-1:0]      rnd_c;
  logic signed [2:0][CXW-1:0] cx_c;
  logic [2:0][CW-1:0]      cs_c;

  always_comb begin
    dep_w = LW'(rsum) - LW'(dlen);
    for (int i = 0; i < 3; i++) begin
      if (dlen == '0) begin
        nm_c[i] = '0;
      end else if (q[i][F]) begin
        nm_c[i] = NMAX;
      end else begin
        nm_c[i] = q[i][F-1:0];
      end
    end
  end

  always_comb begin
    two_ra = {ra1_r, 1'b0};
    sneg_c = (two_ra < depth1_r);
  end

  // round the offset, add to centre A, saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd_c[i] = (prod3_r[i] + (PW'(1) << F)) >> (F + 1);
      if (sn3_r[i]) begin
        cx_c[i] = CXW'($signed(a3_r[i])) - CXW'(rnd_c[i][SCALE_W-1:0]);
      end else begin
        cx_c[i] = CXW'($signed(a3_r[i])) + CXW'(rnd_c[i][SCALE_W-1:0]);
      end
      priority if ($signed(cx_c[i]) > LIM_HI) begin
        cs_c[i] = LIM_HI[CW-1:0];
      end else if ($signed(cx_c[i]) < LIM_LO) begin
        cs_c[i] = LIM_LO[CW-1:0];
      end else begin
        cs_c[i] = cx_c[i][CW-1:0];
      end
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      vld3_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld1_r      <= in_vld;
      vld2_r      <= vld1_r;
      vld3_r      <= vld2_r;
      out_valid_r <= vld3_r;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      hit1_r   <= (LW'(dlen) < LW'(rsum));
      depth1_r <= dep_w[DEPTH_W-1:0];
      nm1_r    <= nm_c;
      a1_r     <= a;
      dn1_r    <= dn;
      ra1_r    <= ra;

      hit2_r   <= hit1_r;
      depth2_r <= depth1_r;
      nm2_r    <= nm1_r;
      a2_r     <= a1_r;
      dn2_r    <= dn1_r;
      smag2_r  <= sneg_c ? (depth1_r - two_ra) : (two_ra - depth1_r);
      sn2_r    <= dn1_r ^ {3{sneg_c}};

      hit3_r   <= hit2_r;
      depth3_r <= depth2_r;
      nm3_r    <= nm2_r;
      a3_r     <= a2_r;
      dn3_r    <= dn2_r;
      sn3_r    <= sn2_r;
      for (int i = 0; i < 3; i++) begin
        prod3_r[i] <= PW'(smag2_r) * PW'(nm2_r[i]);
      end

      // drop every field to zero without contact
      hit4_r   <= hit3_r;
      depth4_r <= hit3_r ? depth3_r : '0;
      for (int i = 0; i < 3; i++) begin
        if (!hit3_r) begin
          norm4_r[i] <= '0;
          cpt4_r[i]  <= '0;
        end else begin
          norm4_r[i] <= dn3_r[i] ? ((F+1)'(0) - {1'b0, nm3_r[i]}) : {1'b0, nm3_r[i]};
          cpt4_r[i]  <= cs_c[i];
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_in_contact = hit4_r;
  assign out_depth      = depth4_r;
  assign out_normal     = norm4_r;
  assign out_contact    = cpt4_r;

  `SPCT_ASSERT_IMP(a_miss_zero, out_valid && !out_in_contact, out_depth == '0 && out_normal == '0 && out_contact == '0, "nonzero fields on a miss")
  `SPCT_ASSERT_IMP(a_hit_depth, out_valid && out_in_contact, out_depth != '0, "contact with zero depth")
  `SPCT_ASSERT_IMP(a_norm_range, out_valid, out_normal[0] != NMIN && out_normal[1] != NMIN && out_normal[2] != NMIN, "normal outside symmetric range")

endmodule

/* src/sphere_pair_contact_test_core.sv */
// ---------------------------------------------------------------------------
// sphere_pair_contact_test_core
// Streaming sphere-sphere contact test with normal, depth and contact point.
// ---------------------------------------------------------------------------
// Takes one sphere pair per clock while in_ready is high and returns one
// result word per pair, in order. Each pair passes the difference and
// squared length, the square root pipeline with one root bit per stage
// (COORD_WIDTH + 1 stages), the normal divider with one quotient bit per
// stage (NORMAL_FRAC_BITS + 1 stages), and then depth, scaling, saturation
// and the output register. The whole pipeline holds while a finished word
// waits on out_ready.
module sphere_pair_contact_test_core #(
  parameter int COORD_WIDTH      = 32,
  parameter int NORMAL_FRAC_BITS = 15
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       in_center_a_x,
  input  logic signed [COORD_WIDTH-1:0]       in_center_a_y,
  input  logic signed [COORD_WIDTH-1:0]       in_center_a_z,
  input  logic signed [COORD_WIDTH-1:0]       in_center_b_x,
  input  logic signed [COORD_WIDTH-1:0]       in_center_b_y,
  input  logic signed [COORD_WIDTH-1:0]       in_center_b_z,
  input  logic [spct_pkg::RADIUS_W-1:0]       in_radius_a,
  input  logic [spct_pkg::RADIUS_W-1:0]       in_radius_b,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_in_contact,
  output logic signed [NORMAL_FRAC_BITS:0]    out_normal_x,
  output logic signed [NORMAL_FRAC_BITS:0]    out_normal_y,
  output logic signed [NORMAL_FRAC_BITS:0]    out_normal_z,
  output logic [spct_pkg::DEPTH_W-1:0]        out_overlap_depth,
  output logic signed [COORD_WIDTH-1:0]       out_contact_x,
  output logic signed [COORD_WIDTH-1:0]       out_contact_y,
  output logic signed [COORD_WIDTH-1:0]       out_contact_z
);
  import spct_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int F   = NORMAL_FRAC_BITS;
  localparam int MW  = CW + 1;
  localparam int SW  = 2 * MW;
  localparam int SD1 = 3 * CW + 3 + 3 * MW + RADIUS_W + RSUM_W;
  localparam int SD2 = 3 * CW + 3 + RADIUS_W + RSUM_W;

  logic               en;
  logic [2:0][CW-1:0] ca, cb;

  logic               s_vld;
  logic [SW-1:0]      s_sq;
  logic [2:0][CW-1:0] s_a;
  logic [2:0]         s_dn;
  logic [2:0][MW-1:0] s_dm;
  logic [RADIUS_W-1:0] s_ra;
  logic [RSUM_W-1:0]  s_rsum;

  logic               r_vld;
  logic [MW-1:0]      r_dist;
  logic [SD1-1:0]     r_side;
  logic [2:0][CW-1:0] r_a;
  logic [2:0]         r_dn;
  logic [2:0][MW-1:0] r_dm;
  logic [RADIUS_W-1:0] r_ra;
  logic [RSUM_W-1:0]  r_rsum;

  logic               n_vld;
  logic [2:0][F:0]    n_q;
  logic [MW-1:0]      n_dist;
  logic [SD2-1:0]     n_side;
  logic [2:0][CW-1:0] n_a;
  logic [2:0]         n_dn;
  logic [RADIUS_W-1:0] n_ra;
  logic [RSUM_W-1:0]  n_rsum;

  logic [2:0][F:0]    o_normal;
  logic [2:0][CW-1:0] o_contact;

  // advance everything unless a finished word is stuck at the output
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign ca = {in_center_a_z, in_center_a_y, in_center_a_x};
  assign cb = {in_center_b_z, in_center_b_y, in_center_b_x};

  spct_sqsum #(.CW(CW), .MW(MW), .SW(SW)) u_sqsum (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .a      (ca),
    .b      (cb),
    .ra     (in_radius_a),
    .rb     (in_radius_b),
    .out_vld(s_vld),
    .sq     (s_sq),
    .a_o    (s_a),
    .dn_o   (s_dn),
    .dm_o   (s_dm),
    .ra_o   (s_ra),
    .rsum_o (s_rsum)
  );

  spct_sqrt #(.RB(MW), .SW(SW), .SIDE_W(SD1)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (s_vld),
    .rad    (s_sq),
    .side   ({s_a, s_dn, s_dm, s_ra, s_rsum}),
    .out_vld(r_vld),
    .root   (r_dist),
    .side_o (r_side)
  );

  assign {r_a, r_dn, r_dm, r_ra, r_rsum} = r_side;

  spct_norm #(.MW(MW), .F(F), .SIDE_W(SD2)) u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (r_vld),
    .dm     (r_dm),
    .dlen   (r_dist),
    .side   ({r_a, r_dn, r_ra, r_rsum}),
    .out_vld(n_vld),
    .q      (n_q),
    .dist_o (n_dist),
    .side_o (n_side)
  );

  assign {n_a, n_dn, n_ra, n_rsum} = n_side;

  spct_contact #(.CW(CW), .MW(MW), .F(F)) u_contact (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_vld        (n_vld),
    .a             (n_a),
    .dn            (n_dn),
    .q             (n_q),
    .dlen          (n_dist),
    .ra            (n_ra),
    .rsum          (n_rsum),
    .out_valid     (out_valid),
    .out_in_contact(out_in_contact),
    .out_normal    (o_normal),
    .out_depth     (out_overlap_depth),
    .out_contact   (o_contact)
  );

  assign out_normal_x  = o_normal[0];
  assign out_normal_y  = o_normal[1];
  assign out_normal_z  = o_normal[2];
  assign out_contact_x = o_contact[0];
  assign out_contact_y = o_contact[1];
  assign out_contact_z = o_contact[2];

endmodule
